// ===== design/order_size_flow_histogram_defines.svh =====
// Assertion macros for the order size flow histogram checker.
`ifndef ORDER_SIZE_FLOW_HISTOGRAM_DEFINES_SVH
`define ORDER_SIZE_FLOW_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define OSFH_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked also during reset.
`define OSFH_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/osfh_pkg.sv =====
// Shared types, constants and helpers of the order size flow histogram.
package osfh_pkg;

    localparam int SYMBOL_COUNT = 1024;
    localparam int DAY_COUNT    = 16;
    localparam int NUM_BUCKETS  = 9;
    localparam int STORE_DEPTH  = NUM_BUCKETS * SYMBOL_COUNT * DAY_COUNT;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam logic [3:0] TOP_BUCKET = 4'd8;
    localparam logic [47:0] VOL_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [63:0] AMT_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [11:0] CUTOFF_RESET = 12'd1500;

    localparam logic FUNC_ACCUM = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    typedef logic [ADDR_W-1:0] addr_t;

    typedef struct packed {
        logic [47:0] vol;
        logic [63:0] amt;
    } total_t;

    typedef struct packed {
        logic   rd;
        logic   wr;
        logic   wr_match;
        addr_t  ib;
        addr_t  io;
        total_t buy;
        total_t sell;
        total_t match;
    } store_req_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_MUL_BID, ST_MUL_OFF, ST_MUL_AMT,
        ST_ADDR, ST_READ, ST_ADD, ST_PUSH
    } state_t;

    // Bucket bounds in cents
    localparam logic [57:0] BOUND [8] = '{
        58'd5000000, 58'd10000000, 58'd20000000, 58'd50000000,
        58'd100000000, 58'd200000000, 58'd500000000, 58'd1000000000
    };

    // Count the bounds that an order value reaches
    function automatic logic [3:0] size_bucket(input logic [57:0] value);
        logic [3:0] b;
        b = 4'd0;
        for (int i = 0; i < 8; i++) begin
            b = b + {3'd0, (value >= BOUND[i])};
        end
        return b;
    endfunction

    function automatic addr_t store_index(input logic [3:0] bucket,
                                          input logic [9:0] sym,
                                          input logic [3:0] day);
        logic [63:0] idx;
        idx = (64'(bucket) * 64'(SYMBOL_COUNT) + 64'(sym)) * 64'(DAY_COUNT) + 64'(day);
        return idx[ADDR_W-1:0];
    endfunction

endpackage

// ===== design/osfh_store.sv =====
// Totals store: buy, sell and matched totals, one memory each.
module osfh_store (
    input  logic                aclk,
    input  osfh_pkg::store_req_t req,
    output osfh_pkg::total_t    buy_q,
    output osfh_pkg::total_t    sell_q,
    output osfh_pkg::total_t    match_q
);
    import osfh_pkg::*;

    total_t buy_mem   [STORE_DEPTH];
    total_t sell_mem  [STORE_DEPTH];
    total_t match_mem [STORE_DEPTH];

    // Write buy and match at the bid index, sell at the offer index
    always_ff @(posedge aclk) begin
        if (req.wr) begin
            buy_mem[req.ib]  <= req.buy;
            sell_mem[req.io] <= req.sell;
            if (req.wr_match) begin
                match_mem[req.ib] <= req.match;
            end
        end
    end

    // Registered read
    always_ff @(posedge aclk) begin
        if (req.rd) begin
            buy_q   <= buy_mem[req.ib];
            sell_q  <= sell_mem[req.io];
            match_q <= match_mem[req.ib];
        end
    end

endmodule

// ===== design/order_size_flow_histogram.sv =====
// Top level of the order size flow histogram.
// After reset the block clears all 9*SYMBOL_COUNT*DAY_COUNT entries of its
// totals store (147456 at the default sizes), one entry a cycle; s_ready
// stays low during that pass while cfg writes are taken. An accumulate
// request then runs through one shared multiplier, which forms bid value,
// offer value and trade amount in turn, then a read and a read-modify-write
// of the store; a read request skips the multiplier. The next request is
// accepted in the cycle after the result is handed to the output register,
// so requests are taken one at a time.
module order_size_flow_histogram (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [11:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [9:0]  s_symbol,
    input  logic [3:0]  s_day_slot,
    input  logic [11:0] s_time_hhmm,
    input  logic        s_is_fill,
    input  logic [23:0] s_trade_price_cents,
    input  logic [31:0] s_trade_volume,
    input  logic [23:0] s_bid_price_cents,
    input  logic [33:0] s_bid_volume,
    input  logic [23:0] s_offer_price_cents,
    input  logic [33:0] s_offer_volume,
    input  logic [3:0]  s_read_bucket,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_bid_bucket,
    output logic [3:0]  m_offer_bucket,
    output logic        m_counted,
    output logic [47:0] m_buy_volume_total,
    output logic [63:0] m_buy_amount_total,
    output logic [47:0] m_sell_volume_total,
    output logic [63:0] m_sell_amount_total,
    output logic [47:0] m_match_volume_total,
    output logic [63:0] m_match_amount_total
);
    import osfh_pkg::*;

    state_t state_reg, state_next;
    logic [11:0] cutoff_reg;
    addr_t clr_reg, clr_next;

    // Captured request
    logic        func_reg, fill_reg, in_range_reg;
    logic [9:0]  sym_reg;
    logic [3:0]  day_reg;
    logic [11:0] time_reg;
    logic [23:0] tprice_reg, bprice_reg, oprice_reg;
    logic [31:0] tvol_reg;
    logic [33:0] bvol_reg, ovol_reg;
    logic [3:0]  bb_reg, ob_reg, rb_sat;
    logic [57:0] prod_reg;
    addr_t       ib_reg, io_reg;
    logic        counted_reg;

    // Pending result
    total_t res_buy_reg, res_sell_reg, res_match_reg;

    logic        m_valid_reg;
    logic        accept, out_free;
    logic [23:0] mul_a;
    logic [33:0] mul_b;
    logic        do_count;
    logic [48:0] bv_sum, sv_sum, mv_sum;
    logic [64:0] ba_sum, sa_sum, ma_sum;
    total_t      new_buy, new_sell, new_match;
    total_t      buy_q, sell_q, match_q;
    store_req_t  req;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign rb_sat    = (s_read_bucket > TOP_BUCKET) ? TOP_BUCKET : s_read_bucket;

    // Hold cutoff register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_reg <= CUTOFF_RESET;
        end else if (cfg_valid && cfg_ready) begin
            cutoff_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + addr_t'(1);
                if (clr_reg == addr_t'(STORE_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = (s_func == FUNC_READ) ? ST_ADDR : ST_MUL_BID;
                end
            end
            ST_MUL_BID: state_next = ST_MUL_OFF;
            ST_MUL_OFF: state_next = ST_MUL_AMT;
            ST_MUL_AMT: state_next = ST_ADDR;
            ST_ADDR:    state_next = ST_READ;
            ST_READ:    state_next = ST_ADD;
            ST_ADD:     state_next = ST_PUSH;
            ST_PUSH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Shared multiplier operand select
    always_comb begin
        case (state_reg)
            ST_MUL_BID: begin
                mul_a = bprice_reg;
                mul_b = bvol_reg;
            end
            ST_MUL_OFF: begin
                mul_a = oprice_reg;
                mul_b = ovol_reg;
            end
            default: begin
                mul_a = tprice_reg;
                mul_b = {2'd0, tvol_reg};
            end
        endcase
    end

    // Capture request, run multiplier and bucket steps
    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg     <= s_func;
            fill_reg     <= s_is_fill;
            sym_reg      <= s_symbol;
            day_reg      <= s_day_slot;
            time_reg     <= s_time_hhmm;
            tprice_reg   <= s_trade_price_cents;
            tvol_reg     <= s_trade_volume;
            bprice_reg   <= s_bid_price_cents;
            bvol_reg     <= s_bid_volume;
            oprice_reg   <= s_offer_price_cents;
            ovol_reg     <= s_offer_volume;
            in_range_reg <= (32'(s_symbol) < 32'(SYMBOL_COUNT))
                         && (32'(s_day_slot) < 32'(DAY_COUNT));
            bb_reg       <= rb_sat;
            ob_reg       <= rb_sat;
        end
        if (state_reg == ST_MUL_BID || state_reg == ST_MUL_OFF
            || state_reg == ST_MUL_AMT) begin
            prod_reg <= 58'(mul_a) * 58'(mul_b);
        end
        if (state_reg == ST_MUL_OFF) begin
            bb_reg <= size_bucket(prod_reg);
        end
        if (state_reg == ST_MUL_AMT) begin
            ob_reg <= size_bucket(prod_reg);
        end
        if (state_reg == ST_ADDR) begin
            ib_reg      <= store_index(bb_reg, sym_reg, day_reg);
            io_reg      <= store_index(ob_reg, sym_reg, day_reg);
            counted_reg <= (func_reg == FUNC_ACCUM) && fill_reg && in_range_reg
                        && (time_reg <= cutoff_reg);
        end
        if (state_reg == ST_ADD) begin
            res_buy_reg   <= in_range_reg ? new_buy : '0;
            res_sell_reg  <= in_range_reg ? new_sell : '0;
            res_match_reg <= in_range_reg ? new_match : '0;
        end
    end

    // Saturating sums of the totals
    assign do_count = counted_reg;
    assign bv_sum = 49'(buy_q.vol) + 49'(tvol_reg);
    assign sv_sum = 49'(sell_q.vol) + 49'(tvol_reg);
    assign mv_sum = 49'(match_q.vol) + 49'(tvol_reg);
    assign ba_sum = 65'(buy_q.amt) + 65'(prod_reg[55:0]);
    assign sa_sum = 65'(sell_q.amt) + 65'(prod_reg[55:0]);
    assign ma_sum = 65'(match_q.amt) + 65'(prod_reg[55:0]);

    always_comb begin
        new_buy   = buy_q;
        new_sell  = sell_q;
        new_match = match_q;
        if (do_count) begin
            new_buy.vol  = bv_sum[48] ? VOL_MAX : bv_sum[47:0];
            new_buy.amt  = ba_sum[64] ? AMT_MAX : ba_sum[63:0];
            new_sell.vol = sv_sum[48] ? VOL_MAX : sv_sum[47:0];
            new_sell.amt = sa_sum[64] ? AMT_MAX : sa_sum[63:0];
            if (bb_reg == ob_reg) begin
                new_match.vol = mv_sum[48] ? VOL_MAX : mv_sum[47:0];
                new_match.amt = ma_sum[64] ? AMT_MAX : ma_sum[63:0];
            end
        end
    end

    // Store request: clear pass, read, or write back
    always_comb begin
        req          = '0;
        req.ib       = ib_reg;
        req.io       = io_reg;
        req.buy      = new_buy;
        req.sell     = new_sell;
        req.match    = new_match;
        req.rd       = (state_reg == ST_READ);
        req.wr       = (state_reg == ST_ADD) && do_count;
        req.wr_match = (bb_reg == ob_reg);
        if (state_reg == ST_CLEAR) begin
            req.wr       = 1'b1;
            req.wr_match = 1'b1;
            req.ib       = clr_reg;
            req.io       = clr_reg;
            req.buy      = '0;
            req.sell     = '0;
            req.match    = '0;
        end
    end

    osfh_store u_store (
        .aclk    (aclk),
        .req     (req),
        .buy_q   (buy_q),
        .sell_q  (sell_q),
        .match_q (match_q)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_PUSH && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_PUSH && out_free) begin
            m_bid_bucket         <= bb_reg;
            m_offer_bucket       <= ob_reg;
            m_counted            <= counted_reg;
            m_buy_volume_total   <= res_buy_reg.vol;
            m_buy_amount_total   <= res_buy_reg.amt;
            m_sell_volume_total  <= res_sell_reg.vol;
            m_sell_amount_total  <= res_sell_reg.amt;
            m_match_volume_total <= res_match_reg.vol;
            m_match_amount_total <= res_match_reg.amt;
        end
    end

endmodule

// ===== design/osfh_checker.sv =====
// Port-level checker for the order size flow histogram, with its bind.
`include "order_size_flow_histogram_defines.svh"

module osfh_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [3:0]  m_bid_bucket,
    input logic [3:0]  m_offer_bucket,
    input logic        m_counted
);
    // Clear pass blocks requests right after reset
    `OSFH_ASSERT_NEXT(a_clear_after_reset, aclk, !aresetn, !s_ready)
    // One request at a time
    `OSFH_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn && s_valid && s_ready, !s_ready)
    // Buckets stay in range
    `OSFH_ASSERT_IMPLY(a_bucket_range, aclk, aresetn, m_valid,
        (m_bid_bucket <= 4'd8) && (m_offer_bucket <= 4'd8))
    // Result holds while stalled
    `OSFH_ASSERT_IMPLY(a_result_holds, aclk, aresetn,
        $past(m_valid && !m_ready) && $past(aresetn), m_valid && $stable(m_counted))

endmodule

bind order_size_flow_histogram osfh_checker u_osfh_checker (.*);

// ===== bench/order_size_flow_histogram_tb.sv =====
// Self-checking testbench of the order size flow histogram.
module order_size_flow_histogram_tb;
    import osfh_pkg::*;

    typedef struct {
        logic        func;
        logic [9:0]  symbol;
        logic [3:0]  day_slot;
        logic [11:0] time_hhmm;
        logic        is_fill;
        logic [23:0] trade_price;
        logic [31:0] trade_volume;
        logic [23:0] bid_price;
        logic [33:0] bid_volume;
        logic [23:0] offer_price;
        logic [33:0] offer_volume;
        logic [3:0]  read_bucket;
    } trade_req_t;

    typedef struct {
        logic [3:0]  bid_bucket;
        logic [3:0]  offer_bucket;
        logic        counted;
        logic [47:0] buy_vol;
        logic [63:0] buy_amt;
        logic [47:0] sell_vol;
        logic [63:0] sell_amt;
        logic [47:0] match_vol;
        logic [63:0] match_amt;
    } flow_totals_t;

    typedef struct {
        trade_req_t   rq;
        bit           typed;
        flow_totals_t totals;
    } stim_row_t;

    // Size bucket bounds in cents
    localparam logic [57:0] SIZE_BOUND_CENTS [8] = '{
        58'd5000000, 58'd10000000, 58'd20000000, 58'd50000000,
        58'd100000000, 58'd200000000, 58'd500000000, 58'd1000000000
    };
    localparam int RANDOM_PER_PHASE = 430;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [11:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_func;
    logic [9:0]  s_symbol;
    logic [3:0]  s_day_slot;
    logic [11:0] s_time_hhmm;
    logic        s_is_fill;
    logic [23:0] s_trade_price_cents;
    logic [31:0] s_trade_volume;
    logic [23:0] s_bid_price_cents;
    logic [33:0] s_bid_volume;
    logic [23:0] s_offer_price_cents;
    logic [33:0] s_offer_volume;
    logic [3:0]  s_read_bucket;
    logic        m_valid;
    logic        m_ready;
    logic [3:0]  m_bid_bucket;
    logic [3:0]  m_offer_bucket;
    logic        m_counted;
    logic [47:0] m_buy_volume_total;
    logic [63:0] m_buy_amount_total;
    logic [47:0] m_sell_volume_total;
    logic [63:0] m_sell_amount_total;
    logic [47:0] m_match_volume_total;
    logic [63:0] m_match_amount_total;

    // Shadow totals, keyed by {bucket, symbol, day}; missing keys read as zero
    logic [47:0] buy_vol_sh [int];
    logic [63:0] buy_amt_sh [int];
    logic [47:0] sell_vol_sh [int];
    logic [63:0] sell_amt_sh [int];
    logic [47:0] match_vol_sh [int];
    logic [63:0] match_amt_sh [int];
    logic [11:0] cutoff_sh;

    flow_totals_t pending_totals [$];
    stim_row_t    rows [$];
    int           errors;
    int           tx_idle;
    int           rx_idle;

    order_size_flow_histogram DUT (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #3000000;
        $display("** order_size_flow_histogram: FAILED **");
        $finish;
    end

    function automatic logic [3:0] order_bucket(input logic [23:0] price,
                                                input logic [33:0] vol);
        logic [57:0] value;
        logic [3:0]  b;
        value = 58'(price) * 58'(vol);
        b = 4'd0;
        for (int i = 0; i < 8; i++)
            if (value >= SIZE_BOUND_CENTS[i]) b = 4'(i + 1);
        return b;
    endfunction

    function automatic logic [47:0] vol_sum(input logic [47:0] a, input logic [31:0] b);
        logic [48:0] s;
        s = {1'b0, a} + 49'(b);
        return s[48] ? VOL_MAX : s[47:0];
    endfunction

    function automatic logic [63:0] amt_sum(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? AMT_MAX : s[63:0];
    endfunction

    function automatic logic [47:0] vol_at(ref logic [47:0] st [int], input int k);
        return st.exists(k) ? st[k] : 48'd0;
    endfunction

    function automatic logic [63:0] amt_at(ref logic [63:0] st [int], input int k);
        return st.exists(k) ? st[k] : 64'd0;
    endfunction

    // Advance the shadow totals by one request and form its result
    function automatic flow_totals_t predict_flow(input trade_req_t r);
        flow_totals_t res;
        logic [63:0]  amt;
        int           kb;
        int           ko;
        if (r.func == FUNC_READ) begin
            res.bid_bucket = (r.read_bucket > TOP_BUCKET) ? TOP_BUCKET : r.read_bucket;
            res.offer_bucket = res.bid_bucket;
        end else begin
            res.bid_bucket = order_bucket(r.bid_price, r.bid_volume);
            res.offer_bucket = order_bucket(r.offer_price, r.offer_volume);
        end
        kb = int'({res.bid_bucket, r.symbol, r.day_slot});
        ko = int'({res.offer_bucket, r.symbol, r.day_slot});
        res.counted = (r.func == FUNC_ACCUM) && r.is_fill && (r.time_hhmm <= cutoff_sh);
        if (res.counted) begin
            amt = 64'(r.trade_price) * 64'(r.trade_volume);
            buy_vol_sh[kb] = vol_sum(vol_at(buy_vol_sh, kb), r.trade_volume);
            buy_amt_sh[kb] = amt_sum(amt_at(buy_amt_sh, kb), amt);
            sell_vol_sh[ko] = vol_sum(vol_at(sell_vol_sh, ko), r.trade_volume);
            sell_amt_sh[ko] = amt_sum(amt_at(sell_amt_sh, ko), amt);
            if (res.bid_bucket == res.offer_bucket) begin
                match_vol_sh[kb] = vol_sum(vol_at(match_vol_sh, kb), r.trade_volume);
                match_amt_sh[kb] = amt_sum(amt_at(match_amt_sh, kb), amt);
            end
        end
        res.buy_vol = vol_at(buy_vol_sh, kb);
        res.buy_amt = amt_at(buy_amt_sh, kb);
        res.sell_vol = vol_at(sell_vol_sh, ko);
        res.sell_amt = amt_at(sell_amt_sh, ko);
        res.match_vol = vol_at(match_vol_sh, kb);
        res.match_amt = amt_at(match_amt_sh, kb);
        return res;
    endfunction

    function automatic trade_req_t accum_req(input logic [9:0] sym, input logic [3:0] day,
            input logic [11:0] t, input logic fill, input logic [23:0] tp,
            input logic [31:0] tv, input logic [23:0] bp, input logic [33:0] bv,
            input logic [23:0] op, input logic [33:0] ov);
        trade_req_t r;
        r = '{FUNC_ACCUM, sym, day, t, fill, tp, tv, bp, bv, op, ov, 4'd0};
        return r;
    endfunction

    function automatic trade_req_t read_req(input logic [9:0] sym, input logic [3:0] day,
                                            input logic [3:0] rb);
        trade_req_t r;
        r = '{FUNC_READ, sym, day, 12'($urandom_range(2359)), 1'($urandom), 24'($urandom),
              $urandom, 24'($urandom), 34'({$urandom, $urandom}), 24'($urandom),
              34'({$urandom, $urandom}), rb};
        return r;
    endfunction

    function automatic logic [33:0] rand_volume();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(3))
            0: return w[33:0];
            1: return 34'($urandom_range(2000));
            2: return 34'($urandom_range(200000));
            default: return 34'($urandom_range(20));
        endcase
    endfunction

    function automatic logic [23:0] rand_price();
        return ($urandom_range(1) == 0) ? 24'($urandom) : 24'($urandom_range(1000000));
    endfunction

    // Mix of hot-cell fills that drive the amount totals to saturation,
    // reads, and general trades favouring a few symbols and days
    function automatic trade_req_t rand_req();
        int          sel;
        logic [9:0]  sym;
        logic [3:0]  day;
        logic [11:0] t;
        sel = $urandom_range(99);
        sym = ($urandom_range(1) == 0) ? 10'($urandom_range(3)) : 10'($urandom);
        if ($urandom_range(3) == 0) sym = 10'd1023;
        day = ($urandom_range(1) == 0) ? 4'($urandom_range(1)) : 4'($urandom);
        t = ($urandom_range(4) == 0) ? cutoff_sh : 12'($urandom_range(2359));
        if ($urandom_range(9) == 0) t = 12'd0;
        if (sel < 25)
            return accum_req(10'd5, 4'd3, 12'd0, 1'b1, 24'hFFFFFF,
                             32'hFFFFFFFF - 32'($urandom_range(255)),
                             24'hFFFFFF, {34{1'b1}}, 24'hFFFFFF, {34{1'b1}});
        if (sel < 32)
            return read_req(10'd5, 4'd3, 4'($urandom_range(15)));
        if (sel < 45)
            return read_req(sym, day, 4'($urandom_range(15)));
        return accum_req(sym, day, t, ($urandom_range(4) != 0), 24'($urandom), $urandom,
                         rand_price(), rand_volume(), rand_price(), rand_volume());
    endfunction

    // Hold the request until accepted, then record what it should return
    task automatic send_req(input trade_req_t r, input bit typed, input flow_totals_t tt);
        flow_totals_t p;
        while ($urandom_range(99) < tx_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= r.func;
        s_symbol <= r.symbol;
        s_day_slot <= r.day_slot;
        s_time_hhmm <= r.time_hhmm;
        s_is_fill <= r.is_fill;
        s_trade_price_cents <= r.trade_price;
        s_trade_volume <= r.trade_volume;
        s_bid_price_cents <= r.bid_price;
        s_bid_volume <= r.bid_volume;
        s_offer_price_cents <= r.offer_price;
        s_offer_volume <= r.offer_volume;
        s_read_bucket <= r.read_bucket;
        do @(posedge aclk); while (!s_ready);
        p = predict_flow(r);
        pending_totals.push_back(typed ? tt : p);
        @(negedge aclk);
    endtask

    task automatic write_cutoff(input logic [11:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cutoff_sh = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_totals.size() != 0) @(negedge aclk);
    endtask

    task automatic run_random(input int n);
        flow_totals_t none;
        none = '{default: '0};
        repeat (n) send_req(rand_req(), 1'b0, none);
    endtask

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    // Compare each returned result with the oldest expectation
    always @(posedge aclk) begin
        flow_totals_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_totals.size() == 0) begin
                $display("%0t unexpected result: expected none, actual buckets %0d/%0d",
                         $time, m_bid_bucket, m_offer_bucket);
                errors++;
            end else begin
                e = pending_totals.pop_front();
                check_field("bid_bucket", 64'(e.bid_bucket), 64'(m_bid_bucket));
                check_field("offer_bucket", 64'(e.offer_bucket), 64'(m_offer_bucket));
                check_field("counted", 64'(e.counted), 64'(m_counted));
                check_field("buy_volume", 64'(e.buy_vol), 64'(m_buy_volume_total));
                check_field("buy_amount", e.buy_amt, m_buy_amount_total);
                check_field("sell_volume", 64'(e.sell_vol), 64'(m_sell_volume_total));
                check_field("sell_amount", e.sell_amt, m_sell_amount_total);
                check_field("match_volume", 64'(e.match_vol), 64'(m_match_volume_total));
                check_field("match_amount", e.match_amt, m_match_amount_total);
            end
        end
    end

    // Stall the result channel at random
    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= rx_idle);
    end

    initial begin
        flow_totals_t zero_t;
        logic [33:0]  vmax;
        errors = 0;
        tx_idle = 9;
        rx_idle = 70;
        cutoff_sh = CUTOFF_RESET;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        m_ready = 1'b0;
        s_valid = 1'b0;
        s_func = FUNC_ACCUM;
        s_symbol = '0;
        s_day_slot = '0;
        s_time_hhmm = '0;
        s_is_fill = 1'b0;
        s_trade_price_cents = '0;
        s_trade_volume = '0;
        s_bid_price_cents = '0;
        s_bid_volume = '0;
        s_offer_price_cents = '0;
        s_offer_volume = '0;
        s_read_bucket = '0;
        zero_t = '{default: '0};
        vmax = {34{1'b1}};

        // Directed table: typed totals where obvious, predictor elsewhere
        rows.push_back('{read_req(10'd0, 4'd0, 4'd0), 1'b1, zero_t});
        rows.push_back('{read_req(10'd1023, 4'd15, 4'd15), 1'b1,
                         '{4'd8, 4'd8, 1'b0, 48'd0, 64'd0, 48'd0, 64'd0, 48'd0, 64'd0}});
        rows.push_back('{accum_req(10'd7, 4'd2, 12'd100, 1'b0, 24'd5, 32'd5, 24'd0, 34'd0,
                                   24'hFFFFFF, vmax), 1'b1,
                         '{4'd0, 4'd8, 1'b0, 48'd0, 64'd0, 48'd0, 64'd0, 48'd0, 64'd0}});
        rows.push_back('{accum_req(10'd7, 4'd2, 12'd2359, 1'b1, 24'd5, 32'd5, 24'd100,
                                   34'd50000, 24'd100, 34'd49999), 1'b1,
                         '{4'd1, 4'd0, 1'b0, 48'd0, 64'd0, 48'd0, 64'd0, 48'd0, 64'd0}});
        rows.push_back('{accum_req(10'd2, 4'd1, 12'd1500, 1'b1, 24'd100, 32'd10, 24'd100,
                                   34'd50000, 24'd100, 34'd50000), 1'b1,
                         '{4'd1, 4'd1, 1'b1, 48'd10, 64'd1000, 48'd10, 64'd1000,
                           48'd10, 64'd1000}});
        rows.push_back('{accum_req(10'd2, 4'd1, 12'd0, 1'b1, 24'd100, 32'd10, 24'd100,
                                   34'd50000, 24'd0, 34'd0), 1'b1,
                         '{4'd1, 4'd0, 1'b1, 48'd20, 64'd2000, 48'd10, 64'd1000,
                           48'd10, 64'd1000}});
        rows.push_back('{accum_req(10'd1023, 4'd15, 12'd0, 1'b1, 24'hFFFFFF, 32'hFFFFFFFF,
                                   24'hFFFFFF, vmax, 24'hFFFFFF, vmax), 1'b0, zero_t});
        rows.push_back('{accum_req(10'd1023, 4'd15, 12'd1501, 1'b1, 24'd1, 32'd1,
                                   24'hFFFFFF, vmax, 24'd1, 34'd0), 1'b0, zero_t});
        rows.push_back('{accum_req(10'd3, 4'd4, 12'd9, 1'b1, 24'd1, 32'd0, 24'd1,
                                   34'd4999999, 24'd1, 34'd9999999), 1'b0, zero_t});
        rows.push_back('{accum_req(10'd3, 4'd4, 12'd9, 1'b1, 24'd7, 32'd3, 24'd1,
                                   34'd10000000, 24'd1, 34'd20000000), 1'b0, zero_t});
        rows.push_back('{accum_req(10'd3, 4'd4, 12'd9, 1'b1, 24'd7, 32'd3, 24'd1,
                                   34'd49999999, 24'd1, 34'd50000000), 1'b0, zero_t});
        rows.push_back('{accum_req(10'd3, 4'd4, 12'd9, 1'b1, 24'd7, 32'd3, 24'd2,
                                   34'd50000000, 24'd1, 34'd200000000), 1'b0, zero_t});
        rows.push_back('{accum_req(10'd3, 4'd4, 12'd9, 1'b1, 24'd7, 32'd3, 24'd1,
                                   34'd499999999, 24'd1, 34'd999999999), 1'b0, zero_t});
        rows.push_back('{accum_req(10'd3, 4'd4, 12'd9, 1'b1, 24'd7, 32'd3, 24'd10,
                                   34'd100000000, 24'd1, 34'd500000000), 1'b0, zero_t});
        rows.push_back('{read_req(10'd3, 4'd4, 4'd8), 1'b0, zero_t});
        rows.push_back('{read_req(10'd3, 4'd4, 4'd9), 1'b0, zero_t});
        rows.push_back('{read_req(10'd2, 4'd1, 4'd1), 1'b0, zero_t});
        rows.push_back('{read_req(10'd1023, 4'd15, 4'd8), 1'b0, zero_t});
        rows.push_back('{read_req(10'd3, 4'd4, 4'd3), 1'b0, zero_t});

        // Hold reset, then load the cutoff while the store clears
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        write_cutoff(12'd1500);

        foreach (rows[i]) send_req(rows[i].rq, rows[i].typed, rows[i].totals);
        run_random(RANDOM_PER_PHASE);
        drain();

        write_cutoff(12'd0);
        tx_idle = 70;
        rx_idle = 9;
        run_random(RANDOM_PER_PHASE);
        drain();

        write_cutoff(12'd2359);
        tx_idle = 0;
        rx_idle = 0;
        run_random(RANDOM_PER_PHASE);
        drain();

        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("** order_size_flow_histogram: PASSED **");
        else
            $display("** order_size_flow_histogram: FAILED **");
        $finish;
    end

endmodule

// ===== order_size_flow_histogram.f =====
+incdir+design
design/osfh_pkg.sv
design/osfh_store.sv
design/order_size_flow_histogram.sv
design/osfh_checker.sv
bench/order_size_flow_histogram_tb.sv
